@@ rtl/tlshmd_pkg.sv @@
`default_nettype none

package tlshmd_pkg;

   localparam int HeaderBytes = 4;
   localparam int HcntWidth   = $clog2(HeaderBytes);

   localparam logic [7:0] KIND_TICKET     = 8'h04;
   localparam logic [7:0] KIND_KEY_UPDATE = 8'h18;
   localparam logic [7:0] NO_KIND         = 8'hFF;

   typedef enum logic [2:0] {
      ST_OK          = 3'd0,
      ST_BAD_TYPE    = 3'd1,
      ST_KU_NOT_LAST = 3'd2,
      ST_RETRIEVED   = 3'd3,
      ST_MID_TICKET  = 3'd4
   } status_type;

   typedef struct packed {
      logic       func;
      logic [7:0] byte_value;
      logic       last_in_record;
   } item_type;

   typedef struct packed {
      logic       ticket_byte_valid;
      logic [7:0] ticket_byte;
      logic [1:0] ticket_slot;
      logic       ticket_end;
      logic       record_done;
      status_type status;
      logic       expecting_more;
      logic       had_key_update;
      logic [7:0] key_update_kind;
      logic       had_ticket;
      logic [2:0] tickets_held;
   } result_type;

endpackage

`default_nettype wire

@@ rtl/tlshmd_parser.sv @@
`default_nettype none

module tlshmd_parser #(
   parameter int MaxTickets = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  tlshmd_pkg::item_type   item,
   output tlshmd_pkg::result_type result
);
   import tlshmd_pkg::*;

   localparam logic [3:0] MaxTicketsW = 4'(MaxTickets);

   logic                 data_ff,   data_in;
   logic [HcntWidth-1:0] hcnt_ff,   hcnt_in;
   logic [7:0]           kind_ff,   kind_in;
   logic [23:0]          rem_ff,    rem_in;
   logic [2:0]           tcnt_ff,   tcnt_in;
   logic                 retr_ff,   retr_in;
   logic                 keep_ff,   keep_in;
   logic [1:0]           rflags_ff, rflags_in;
   logic                 first_ff,  first_in;
   logic [7:0]           kuv_ff,    kuv_in;
   logic                 failed_ff;
   status_type           err_ff;

   logic       complete;
   logic       fail;
   status_type fail_code;
   logic [7:0] b;
   result_type res;

   assign b      = item.byte_value;
   assign result = res;

   always_comb begin
      data_in   = data_ff;
      hcnt_in   = hcnt_ff;
      kind_in   = kind_ff;
      rem_in    = rem_ff;
      tcnt_in   = tcnt_ff;
      retr_in   = retr_ff;
      keep_in   = keep_ff;
      rflags_in = rflags_ff;
      first_in  = first_ff;
      kuv_in    = kuv_ff;
      complete  = 1'b0;
      fail      = 1'b0;
      fail_code = ST_OK;
      res                 = '0;
      res.key_update_kind = NO_KIND;
      if (failed_ff) begin
         res.record_done = 1'b1;
         res.status      = err_ff;
      end else if (item.func) begin
         if (retr_ff) begin
            fail      = 1'b1;
            fail_code = ST_RETRIEVED;
         end else if ((data_ff || hcnt_ff != '0) && kind_ff == KIND_TICKET) begin
            fail      = 1'b1;
            fail_code = ST_MID_TICKET;
         end else begin
            retr_in             = 1'b1;
            tcnt_in             = '0;
            res.key_update_kind = '0;
         end
      end else begin
         if (!data_ff) begin
            if (hcnt_ff == '0) begin
               if (b != KIND_TICKET && b != KIND_KEY_UPDATE) begin
                  fail      = 1'b1;
                  fail_code = ST_BAD_TYPE;
               end else begin
                  kind_in = b;
                  rem_in  = '0;
                  kuv_in  = NO_KIND;
                  keep_in = (b == KIND_TICKET) && !retr_ff &&
                            ({1'b0, tcnt_ff} < MaxTicketsW) && (tcnt_ff != 3'd7);
               end
            end else begin
               rem_in = {rem_ff[15:0], b};
            end
            hcnt_in = hcnt_ff + HcntWidth'(1);
            if (hcnt_ff == HcntWidth'(HeaderBytes - 1)) begin
               hcnt_in = '0;
               if (rem_in != '0) begin
                  data_in  = 1'b1;
                  first_in = 1'b1;
               end else begin
                  complete = 1'b1;
               end
            end
         end else begin
            if (first_ff) begin
               kuv_in   = b;
               first_in = 1'b0;
            end
            rem_in = rem_ff - 24'd1;
            if (rem_in == '0) begin
               data_in  = 1'b0;
               complete = 1'b1;
            end
         end

         rflags_in = rflags_ff | ((kind_in == KIND_KEY_UPDATE) ? 2'b01 : 2'b10);

         if (complete && kind_in == KIND_KEY_UPDATE && !item.last_in_record) begin
            fail      = 1'b1;
            fail_code = ST_KU_NOT_LAST;
         end else begin
            if (kind_in == KIND_TICKET && keep_in) begin
               res.ticket_byte_valid = 1'b1;
               res.ticket_byte       = b;
               res.ticket_slot       = tcnt_ff[1:0];
               res.ticket_end        = complete;
               if (complete) begin
                  if (tcnt_ff != 3'd7) begin
                     tcnt_in = tcnt_ff + 3'd1;
                  end
                  keep_in = 1'b0;
               end
            end
            if (complete) begin
               first_in = 1'b0;
            end
            if (item.last_in_record) begin
               res.record_done    = 1'b1;
               res.expecting_more = data_in || (hcnt_in != '0);
               res.had_key_update = rflags_in[0];
               res.had_ticket     = rflags_in[1];
               if (complete && kind_in == KIND_KEY_UPDATE) begin
                  res.key_update_kind = kuv_in;
               end
               rflags_in = '0;
            end
            res.tickets_held = tcnt_in;
         end
      end
      if (fail) begin
         res                 = '0;
         res.key_update_kind = NO_KIND;
         res.record_done     = 1'b1;
         res.status          = fail_code;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         data_ff   <= 1'b0;
         hcnt_ff   <= '0;
         kind_ff   <= '0;
         rem_ff    <= '0;
         tcnt_ff   <= '0;
         retr_ff   <= 1'b0;
         keep_ff   <= 1'b0;
         rflags_ff <= '0;
         first_ff  <= 1'b0;
         kuv_ff    <= NO_KIND;
         failed_ff <= 1'b0;
         err_ff    <= ST_OK;
      end else if (accept && !failed_ff) begin
         if (fail) begin
            failed_ff <= 1'b1;
            err_ff    <= fail_code;
         end else begin
            data_ff   <= data_in;
            hcnt_ff   <= hcnt_in;
            kind_ff   <= kind_in;
            rem_ff    <= rem_in;
            tcnt_ff   <= tcnt_in;
            retr_ff   <= retr_in;
            keep_ff   <= keep_in;
            rflags_ff <= rflags_in;
            first_ff  <= first_in;
            kuv_ff    <= kuv_in;
         end
      end
   end

   a_failed_sticky: assert property (@(posedge clock) disable iff (reset)
      failed_ff |=> failed_ff)
      else $error("error state left without reset");

   a_data_nonzero: assert property (@(posedge clock) disable iff (reset)
      data_ff |-> rem_ff != '0)
      else $error("data phase with nothing remaining");

   a_header_not_data: assert property (@(posedge clock) disable iff (reset)
      hcnt_ff != '0 |-> !data_ff)
      else $error("header and data phase together");

   a_keep_ticket: assert property (@(posedge clock) disable iff (reset)
      keep_ff |-> (kind_ff == KIND_TICKET && !retr_ff))
      else $error("ticket kept after retrieval or for wrong kind");

   a_keep_room: assert property (@(posedge clock) disable iff (reset)
      keep_ff |-> ({1'b0, tcnt_ff} < MaxTicketsW))
      else $error("ticket kept with no room");

endmodule

`default_nettype wire

@@ rtl/tls_handshake_message_deframer.sv @@
// Channel | Direction | tdata (low bit up)                       | tlast / tuser
// req     | in        | byte_value                               | last_in_record / func
// rsp     | out       | ticket_byte, ticket_slot, record_done,   | ticket_end /
//         |           | status, expecting_more, had_key_update,  |   ticket_byte_valid
//         |           | key_update_kind, had_ticket, tickets_held|
// One item per clock while the result is not stalled; the result is registered and
// appears in the cycle after acceptance, from the single register after the parse logic.
// Synchronous reset clears the parse state; the result register is emptied.
// A stalled result holds; req_tready stays high while the result is taken.
`default_nettype none

module tls_handshake_message_deframer #(
   parameter int MaxTickets = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] byte_value
   input  logic        req_tlast,   // last_in_record
   input  logic        req_tuser,   // func
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [7:0] ticket_byte, [9:8] ticket_slot,
                                    // [10] record_done, [13:11] status,
                                    // [14] expecting_more, [15] had_key_update,
                                    // [23:16] key_update_kind, [24] had_ticket,
                                    // [27:25] tickets_held, [31:28] zero
   output logic        rsp_tlast,   // ticket_end
   output logic        rsp_tuser    // ticket_byte_valid
);
   import tlshmd_pkg::*;

   logic       accept;
   item_type   item;
   result_type result;
   result_type rsp_ff;
   logic       rsp_valid_ff;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   assign item.func           = req_tuser;
   assign item.byte_value     = req_tdata;
   assign item.last_in_record = req_tlast;

   tlshmd_parser #(
      .MaxTickets (MaxTickets)
   ) u_parser (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .item   (item),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.ticket_byte_valid;
   assign rsp_tlast  = rsp_ff.ticket_end;
   assign rsp_tdata  = {4'b0000,
                        rsp_ff.tickets_held,
                        rsp_ff.had_ticket,
                        rsp_ff.key_update_kind,
                        rsp_ff.had_key_update,
                        rsp_ff.expecting_more,
                        rsp_ff.status,
                        rsp_ff.record_done,
                        rsp_ff.ticket_slot,
                        rsp_ff.ticket_byte};

endmodule

`default_nettype wire

@@ tb/sv/tb.sv @@
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import tlshmd_pkg::*;

   localparam int   MAX_TICKETS   = 4;
   localparam int   PHASE_ITEMS   = 160;
   localparam logic FUNC_BYTE     = 1'b0;
   localparam logic FUNC_RETRIEVE = 1'b1;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;
   logic        req_tlast  = 1'b0;
   logic        req_tuser  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        rsp_tlast;
   logic        rsp_tuser;

   tls_handshake_message_deframer #(.MaxTickets(MAX_TICKETS)) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tlast(req_tlast),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast),
      .rsp_tuser(rsp_tuser)
   );

   always #4 clock = ~clock;

   int         send_idle_pct = 0;
   int         stall_pct     = 0;
   int         failures      = 0;
   int         sent_items    = 0;
   int         keep_budget   = 0;
   status_type error_kind;
   result_type pending_results[$];

   // deframer state as seen by the predictor
   logic        p_in_data    = 1'b0;
   logic        p_first_data = 1'b0;
   logic        p_retrieved  = 1'b0;
   logic        p_keeping    = 1'b0;
   logic        p_failed     = 1'b0;
   int          p_hdr_count  = 0;
   logic [7:0]  p_kind       = 8'h00;
   logic [7:0]  p_ku_kind    = NO_KIND;
   logic [23:0] p_remaining  = 24'h0;
   logic [2:0]  p_held       = 3'd0;
   logic [1:0]  p_rec_flags  = 2'b00;
   status_type  p_err        = ST_OK;

   function automatic result_type sticky_error(input status_type code);
      result_type r;
      if (!p_failed) begin
         p_failed = 1'b1;
         p_err    = code;
      end
      r                 = '0;
      r.record_done     = 1'b1;
      r.status          = p_err;
      r.key_update_kind = NO_KIND;
      return r;
   endfunction

   function automatic result_type deframe_item(input logic func, input logic [7:0] value,
                                               input logic last);
      result_type r;
      logic       done;
      r                 = '0;
      r.key_update_kind = NO_KIND;
      done              = 1'b0;
      if (p_failed)
         return sticky_error(p_err);
      if (func == FUNC_RETRIEVE) begin
         if (p_retrieved)
            return sticky_error(ST_RETRIEVED);
         if ((p_in_data || p_hdr_count != 0) && p_kind == KIND_TICKET)
            return sticky_error(ST_MID_TICKET);
         p_retrieved       = 1'b1;
         p_held            = 3'd0;
         r.key_update_kind = 8'h00;
         return r;
      end
      if (!p_in_data) begin
         if (p_hdr_count == 0) begin
            if (value != KIND_TICKET && value != KIND_KEY_UPDATE)
               return sticky_error(ST_BAD_TYPE);
            p_kind      = value;
            p_remaining = 24'h0;
            p_ku_kind   = NO_KIND;
            p_keeping   = value == KIND_TICKET && !p_retrieved &&
                          p_held < MAX_TICKETS && p_held != 3'd7;
         end else begin
            p_remaining = {p_remaining[15:0], value};
         end
         p_hdr_count++;
         if (p_hdr_count >= HeaderBytes) begin
            p_hdr_count = 0;
            if (p_remaining != 24'h0) begin
               p_in_data    = 1'b1;
               p_first_data = 1'b1;
            end else begin
               done = 1'b1;
            end
         end
      end else begin
         if (p_first_data) begin
            p_ku_kind    = value;
            p_first_data = 1'b0;
         end
         p_remaining = p_remaining - 24'd1;
         if (p_remaining == 24'h0) begin
            p_in_data = 1'b0;
            done      = 1'b1;
         end
      end
      p_rec_flags |= (p_kind == KIND_KEY_UPDATE) ? 2'b01 : 2'b10;
      if (done && p_kind == KIND_KEY_UPDATE && !last)
         return sticky_error(ST_KU_NOT_LAST);
      if (p_kind == KIND_TICKET && p_keeping) begin
         r.ticket_byte_valid = 1'b1;
         r.ticket_byte       = value;
         r.ticket_slot       = p_held[1:0];
         r.ticket_end        = done;
         if (done) begin
            if (p_held != 3'd7)
               p_held = p_held + 3'd1;
            p_keeping = 1'b0;
         end
      end
      if (done)
         p_first_data = 1'b0;
      if (last) begin
         r.record_done    = 1'b1;
         r.expecting_more = p_in_data || p_hdr_count != 0;
         r.had_key_update = p_rec_flags[0];
         if (done && p_kind == KIND_KEY_UPDATE)
            r.key_update_kind = p_ku_kind;
         r.had_ticket = p_rec_flags[1];
         p_rec_flags  = 2'b00;
      end
      r.tickets_held = p_held;
      return r;
   endfunction

   // entered and left at a falling edge; tvalid stays high for a following item
   task automatic send_item(input logic func, input logic [7:0] value, input logic last);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= value;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      pending_results.insert(pending_results.size(), deframe_item(func, value, last));
      sent_items++;
      @(negedge clock);
   endtask

   // one well-formed message; retrieve_at >= 0 puts a retrieve before that byte of a key update
   task automatic send_message(input int retrieve_at);
      logic [7:0]  kind;
      logic [23:0] len;
      logic [7:0]  value;
      logic        last;
      bit          keep;
      int          total;
      keep = !p_retrieved && p_held < MAX_TICKETS;
      kind = $urandom_range(1) ? KIND_TICKET : KIND_KEY_UPDATE;
      if (retrieve_at >= 0 || (keep && keep_budget == 0))
         kind = KIND_KEY_UPDATE;
      if (kind == KIND_TICKET && keep) begin
         keep_budget--;
         len = 24'($urandom_range(20, 3));
      end else if ($urandom_range(15) == 0) begin
         len = 24'($urandom_range(300, 10));
      end else begin
         len = 24'($urandom_range(9, 0));
      end
      total = 4 + int'(len);
      for (int i = 0; i < total; i++) begin
         if (i == retrieve_at)
            send_item(FUNC_RETRIEVE, 8'($urandom), 1'($urandom));
         case (i)
            0: value = kind;
            1: value = len[23:16];
            2: value = len[15:8];
            3: value = len[7:0];
            default: value = 8'($urandom);
         endcase
         last = ($urandom_range(4) == 0);
         if (kind == KIND_KEY_UPDATE && i == total - 1)
            last = 1'b1;
         send_item(FUNC_BYTE, value, last);
      end
   endtask

   task automatic test_directed();
      // empty key update closing its record
      send_item(FUNC_BYTE, KIND_KEY_UPDATE, 1'b0);
      send_item(FUNC_BYTE, 8'h00, 1'b0);
      send_item(FUNC_BYTE, 8'h00, 1'b0);
      send_item(FUNC_BYTE, 8'h00, 1'b1);
      // header split over two records
      send_item(FUNC_BYTE, KIND_KEY_UPDATE, 1'b1);
      send_item(FUNC_BYTE, 8'h00, 1'b0);
      send_item(FUNC_BYTE, 8'h00, 1'b0);
      send_item(FUNC_BYTE, 8'h01, 1'b0);
      send_item(FUNC_BYTE, 8'h00, 1'b1);
      // empty kept ticket, then a key update in the same record
      send_item(FUNC_BYTE, KIND_TICKET, 1'b0);
      send_item(FUNC_BYTE, 8'h00, 1'b0);
      send_item(FUNC_BYTE, 8'h00, 1'b0);
      send_item(FUNC_BYTE, 8'h00, 1'b0);
      send_item(FUNC_BYTE, KIND_KEY_UPDATE, 1'b0);
      send_item(FUNC_BYTE, 8'h00, 1'b0);
      send_item(FUNC_BYTE, 8'h00, 1'b0);
      send_item(FUNC_BYTE, 8'h02, 1'b0);
      send_item(FUNC_BYTE, 8'hFF, 1'b0);
      send_item(FUNC_BYTE, 8'h7A, 1'b1);
   endtask

   task automatic test_random_phase(input int idle_pct, input int stall, input bit retrieve);
      int first;
      int retrieve_point;
      first          = sent_items;
      send_idle_pct  = idle_pct;
      stall_pct      = stall;
      keep_budget    = 1;
      retrieve_point = $urandom_range(PHASE_ITEMS - 20, 20);
      while (sent_items - first < PHASE_ITEMS) begin
         if (retrieve && !p_retrieved && sent_items - first >= retrieve_point)
            send_message($urandom_range(3));
         else
            send_message(-1);
      end
   endtask

   // one error per run, since it holds until reset
   task automatic test_sticky_error();
      logic [7:0] opening [6];
      logic [7:0] bad;
      int         n;
      opening = '{KIND_TICKET, 8'hFF, 8'hFF, 8'hFF, 8'($urandom), 8'($urandom)};
      send_idle_pct = 6;
      stall_pct     = 6;
      case (error_kind)
         ST_BAD_TYPE: begin
            do bad = 8'($urandom); while (bad == KIND_TICKET || bad == KIND_KEY_UPDATE);
            send_item(FUNC_BYTE, bad, 1'($urandom));
         end
         ST_KU_NOT_LAST: begin
            send_item(FUNC_BYTE, KIND_KEY_UPDATE, 1'b0);
            send_item(FUNC_BYTE, 8'h00, 1'b0);
            send_item(FUNC_BYTE, 8'h00, 1'b0);
            send_item(FUNC_BYTE, 8'h01, 1'b0);
            send_item(FUNC_BYTE, 8'($urandom), 1'b0);
         end
         default: begin
            n = $urandom_range(6, 1);
            for (int i = 0; i < n; i++)
               send_item(FUNC_BYTE, opening[i], 1'($urandom));
            send_item(FUNC_RETRIEVE, 8'($urandom), 1'($urandom));
         end
      endcase
      repeat (8) send_item(1'($urandom), 8'($urandom), 1'($urandom));
   endtask

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   task automatic check_field(input string name, input logic [7:0] want,
                              input logic [7:0] got);
      if (got !== want) begin
         failures++;
         $display("%0t %s: expected %0h, got %0h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin : check_results
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            failures++;
            $display("%0t result item with none expected: expected nothing, got %0h",
                     $time, rsp_tdata);
         end else begin
            want = pending_results.pop_front();
            check_field("ticket_byte_valid", 8'(want.ticket_byte_valid), 8'(rsp_tuser));
            check_field("ticket_byte", want.ticket_byte, rsp_tdata[7:0]);
            check_field("ticket_slot", 8'(want.ticket_slot), 8'(rsp_tdata[9:8]));
            check_field("ticket_end", 8'(want.ticket_end), 8'(rsp_tlast));
            check_field("record_done", 8'(want.record_done), 8'(rsp_tdata[10]));
            check_field("status", 8'(want.status), 8'(rsp_tdata[13:11]));
            check_field("expecting_more", 8'(want.expecting_more), 8'(rsp_tdata[14]));
            check_field("had_key_update", 8'(want.had_key_update), 8'(rsp_tdata[15]));
            check_field("key_update_kind", want.key_update_kind, rsp_tdata[23:16]);
            check_field("had_ticket", 8'(want.had_ticket), 8'(rsp_tdata[24]));
            check_field("tickets_held", 8'(want.tickets_held), 8'(rsp_tdata[27:25]));
            check_field("padding", 8'h00, 8'(rsp_tdata[31:28]));
         end
      end
   end

   initial begin
      error_kind = status_type'($urandom_range(4, 1));
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random_phase(63, 0, 1'b0);
      test_random_phase(0, 63, 1'b0);
      test_random_phase(6, 6, 1'b0);
      test_random_phase(0, 0, error_kind != ST_MID_TICKET);
      test_sticky_error();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
      if (failures == 0)
         $display("PASS tls_handshake_message_deframer");
      else
         $display("FAIL tls_handshake_message_deframer");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("FAIL tls_handshake_message_deframer");
      $finish;
   end

endmodule
